### sv/uds_pkg.sv
// Shared types, sizes and elaboration-time scaling tables for the UYVY downscaler.
package uds_pkg;

  localparam int SRC_WIDTH  = 320;
  localparam int SRC_HEIGHT = 240;
  localparam int OUT_SIZE   = 128;

  localparam int PAIRS_PER_ROW = (SRC_WIDTH + 1) / 2;

  // counter and table widths
  localparam int PC_W = (PAIRS_PER_ROW > 1) ? $clog2(PAIRS_PER_ROW) : 1;
  localparam int SR_W = $clog2(SRC_HEIGHT + 1);
  localparam int OC_W = $clog2(OUT_SIZE + 1);
  localparam int OI_W = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
  localparam int CT_W = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int RT_W = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;

  // conversion coefficients, scaled by 1024
  localparam int CHROMA_OFS = 128;
  localparam int COEF_R_V   = 1436;
  localparam int COEF_G_U   = 352;
  localparam int COEF_G_V   = 731;
  localparam int COEF_B_U   = 1814;
  localparam int COEF_SHIFT = 10;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] chroma_blue;
    logic [7:0] luma_even;
    logic [7:0] chroma_red;
    logic [7:0] luma_odd;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] out_x;
    logic [6:0] out_y;
    logic       frame_last;
  } out_t;

  // picked pixel handed from the position tracker to the color converter
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic [6:0] out_x;
    logic [6:0] out_y;
    logic       frame_last;
  } pick_t;

  typedef logic [CT_W-1:0] col_tab_t [OUT_SIZE];
  typedef logic [RT_W-1:0] row_tab_t [OUT_SIZE];
  typedef logic [OC_W-1:0] step_tab_t [OUT_SIZE];

  function automatic int col_target(int o);
    int t;
    t = (o * SRC_WIDTH) / OUT_SIZE;
    if (t >= SRC_WIDTH) t = SRC_WIDTH - 1;
    return t;
  endfunction

  function automatic int row_target(int o);
    int t;
    t = (o * SRC_HEIGHT) / OUT_SIZE;
    if (t >= SRC_HEIGHT) t = SRC_HEIGHT - 1;
    return t;
  endfunction

  function automatic col_tab_t build_col_tgt();
    col_tab_t tab;
    for (int o = 0; o < OUT_SIZE; o++) tab[o] = CT_W'(col_target(o));
    return tab;
  endfunction

  function automatic row_tab_t build_row_tgt();
    row_tab_t tab;
    for (int o = 0; o < OUT_SIZE; o++) tab[o] = RT_W'(row_target(o));
    return tab;
  endfunction

  // next output column whose source pair lies beyond the pair of column o
  function automatic step_tab_t build_next_col();
    step_tab_t tab;
    int n;
    for (int o = 0; o < OUT_SIZE; o++) begin
      n = o + 1;
      while (n < OUT_SIZE && (col_target(n) / 2) <= (col_target(o) / 2)) n++;
      tab[o] = OC_W'(n);
    end
    return tab;
  endfunction

  // next output row whose source row lies beyond the row of output row o
  function automatic step_tab_t build_next_row();
    step_tab_t tab;
    int n;
    for (int o = 0; o < OUT_SIZE; o++) begin
      n = o + 1;
      while (n < OUT_SIZE && row_target(n) <= row_target(o)) n++;
      tab[o] = OC_W'(n);
    end
    return tab;
  endfunction

  localparam col_tab_t  COL_TGT  = build_col_tgt();
  localparam row_tab_t  ROW_TGT  = build_row_tgt();
  localparam step_tab_t NEXT_COL = build_next_col();
  localparam step_tab_t NEXT_ROW = build_next_row();

endpackage

### sv/uds_pick.sv
// Source position tracking, nearest-neighbor pixel pick and first pipeline register.
module uds_pick (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_xfer,
  input  uds_pkg::in_t   in_data,
  input  logic           s1_take,
  output logic           s1_valid,
  output uds_pkg::pick_t s1_data
);

  logic [uds_pkg::PC_W-1:0] pair_column_r, pair_column_nxt;
  logic [uds_pkg::SR_W-1:0] source_row_r, source_row_nxt;
  logic [uds_pkg::OC_W-1:0] output_column_r, output_column_nxt;
  logic [uds_pkg::OC_W-1:0] output_row_r, output_row_nxt;

  logic [uds_pkg::PC_W-1:0] pc;
  logic [uds_pkg::SR_W-1:0] sr;
  logic [uds_pkg::OC_W-1:0] oc;
  logic [uds_pkg::OC_W-1:0] orow;
  logic [uds_pkg::CT_W-1:0] col_tgt;
  logic [uds_pkg::RT_W-1:0] row_tgt;
  logic [uds_pkg::OC_W-1:0] nxt_col;
  logic [uds_pkg::OC_W-1:0] nxt_row;
  logic                     in_frame;
  logic                     row_active;
  logic                     hit;
  uds_pkg::pick_t           pick;

  logic           s1_valid_r;
  uds_pkg::pick_t s1_data_r;

  always_comb begin
    // frame start restarts every counter before this pair is looked at
    pc   = in_data.frame_start ? '0 : pair_column_r;
    sr   = in_data.frame_start ? '0 : source_row_r;
    oc   = in_data.frame_start ? '0 : output_column_r;
    orow = in_data.frame_start ? '0 : output_row_r;

    col_tgt = uds_pkg::COL_TGT[oc[uds_pkg::OI_W-1:0]];
    row_tgt = uds_pkg::ROW_TGT[orow[uds_pkg::OI_W-1:0]];
    nxt_col = uds_pkg::NEXT_COL[oc[uds_pkg::OI_W-1:0]];
    nxt_row = uds_pkg::NEXT_ROW[orow[uds_pkg::OI_W-1:0]];

    in_frame   = sr < uds_pkg::SR_W'(uds_pkg::SRC_HEIGHT);
    row_active = in_frame && (orow < uds_pkg::OC_W'(uds_pkg::OUT_SIZE)) &&
                 (sr == uds_pkg::SR_W'(row_tgt));
    hit        = row_active && (oc < uds_pkg::OC_W'(uds_pkg::OUT_SIZE)) &&
                 ((col_tgt >> 1) == uds_pkg::CT_W'(pc));

    pair_column_nxt   = pc;
    source_row_nxt    = sr;
    output_column_nxt = oc;
    output_row_nxt    = orow;
    if (in_frame) begin
      if (hit) begin
        output_column_nxt = nxt_col;
      end
      if (pc == uds_pkg::PC_W'(uds_pkg::PAIRS_PER_ROW - 1)) begin
        pair_column_nxt = '0;
        if (row_active) begin
          output_row_nxt    = nxt_row;
          output_column_nxt = '0;
        end
        source_row_nxt = sr + uds_pkg::SR_W'(1);
      end else begin
        pair_column_nxt = pc + uds_pkg::PC_W'(1);
      end
    end

    pick.luma        = col_tgt[0] ? in_data.luma_odd : in_data.luma_even;
    pick.chroma_blue = in_data.chroma_blue;
    pick.chroma_red  = in_data.chroma_red;
    pick.out_x       = 7'(oc);
    pick.out_y       = 7'(orow);
    pick.frame_last  = (nxt_col >= uds_pkg::OC_W'(uds_pkg::OUT_SIZE)) &&
                       (nxt_row >= uds_pkg::OC_W'(uds_pkg::OUT_SIZE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_column_r   <= '0;
      source_row_r    <= '0;
      output_column_r <= '0;
      output_row_r    <= '0;
      s1_valid_r      <= 1'b0;
    end else if (in_xfer) begin
      pair_column_r   <= pair_column_nxt;
      source_row_r    <= source_row_nxt;
      output_column_r <= output_column_nxt;
      output_row_r    <= output_row_nxt;
      s1_valid_r      <= hit;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= pick;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

### sv/uds_csc.sv
// YCbCr to RGB888 conversion with fixed-point coefficients and clamping.
module uds_csc (
  input  uds_pkg::pick_t pick,
  output uds_pkg::out_t  pix
);

  logic signed [8:0]  u_s;
  logic signed [8:0]  v_s;
  logic signed [19:0] r_p, gu_p, gv_p, b_p;
  logic signed [19:0] r_q, gu_q, gv_q, b_q;
  logic signed [10:0] y_s;
  logic signed [10:0] r_s, g_s, b_s;

  function automatic logic [7:0] clamp8(logic signed [10:0] x);
    logic [7:0] res;
    if (x < 11'sd0) res = 8'd0;
    else if (x > 11'sd255) res = 8'd255;
    else res = x[7:0];
    return res;
  endfunction

  always_comb begin
    u_s = $signed({1'b0, pick.chroma_blue}) - 9'(uds_pkg::CHROMA_OFS);
    v_s = $signed({1'b0, pick.chroma_red}) - 9'(uds_pkg::CHROMA_OFS);

    r_p  = 20'(v_s) * $signed(20'(uds_pkg::COEF_R_V));
    gu_p = 20'(u_s) * $signed(20'(uds_pkg::COEF_G_U));
    gv_p = 20'(v_s) * $signed(20'(uds_pkg::COEF_G_V));
    b_p  = 20'(u_s) * $signed(20'(uds_pkg::COEF_B_U));

    // arithmetic shift gives floor for negative products
    r_q  = r_p >>> uds_pkg::COEF_SHIFT;
    gu_q = gu_p >>> uds_pkg::COEF_SHIFT;
    gv_q = gv_p >>> uds_pkg::COEF_SHIFT;
    b_q  = b_p >>> uds_pkg::COEF_SHIFT;

    y_s = $signed(11'({3'b000, pick.luma}));
    r_s = y_s + $signed(11'(r_q));
    g_s = y_s - $signed(11'(gu_q)) - $signed(11'(gv_q));
    b_s = y_s + $signed(11'(b_q));

    pix.red        = clamp8(r_s);
    pix.green      = clamp8(g_s);
    pix.blue       = clamp8(b_s);
    pix.out_x      = pick.out_x;
    pix.out_y      = pick.out_y;
    pix.frame_last = pick.frame_last;
  end

endmodule

### sv/uyvy_downscale_to_rgb_unit.sv
// Top level: UYVY pair stream in, nearest-neighbor downscaled RGB888 pixels out.
//
//   channel | ports                           | payload
//   --------+---------------------------------+----------------------------
//   input   | in_valid, in_stall, in_data     | one UYVY pair + frame start
//   result  | out_valid, out_stall, out_data  | RGB pixel, x/y, last flag
//
// One pair is accepted every cycle unless in_stall is high; a picked pixel
// passes the position/pick register, then the conversion register.
// Pairs that pick no pixel leave a bubble and produce no result.
// Reset clears the position counters and both valid flags.
// out_stall backs up through the two registers to in_stall combinationally.
module uyvy_downscale_to_rgb_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  uds_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output uds_pkg::out_t out_data
);

  logic           in_xfer;
  logic           out_ready;
  logic           s1_valid;
  uds_pkg::pick_t s1_data;
  uds_pkg::out_t  pix;

  logic           out_valid_r;
  uds_pkg::out_t  out_data_r;

  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid && !out_ready;
  assign in_xfer   = in_valid && !in_stall;

  uds_pick u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_xfer  (in_xfer),
    .in_data  (in_data),
    .s1_take  (out_ready),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  uds_csc u_csc (
    .pick (s1_data),
    .pix  (pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      out_data_r <= pix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
